@@ hw/rtl/cfpq_pkg.sv @@
// shared types, codes and widths of the can frame priority queue
package cfpq_pkg;

    localparam int FILL_W = 5;
    localparam int ID_W   = 29;
    localparam int DLC_W  = 4;
    localparam int DATA_W = 64;
    localparam int STD_ID_W = 11;

    typedef logic [1:0] cmd_code_t;

    localparam cmd_code_t CMD_APPEND = 2'd0;
    localparam cmd_code_t CMD_INSERT = 2'd1;
    localparam cmd_code_t CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [DLC_W-1:0]  dlc;
        logic              rtr;
        logic              ide;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_PLACE,
        S_FRONT_RD,
        S_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    append;
        logic    walk_start;
        logic    walk_shift;
        logic    walk_place;
        logic    remove;
        logic    front_rd;
        logic    out_load;
        logic    status_we;
        status_t status_val;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic      in_fire;
        cmd_code_t cmd;
        logic      full;
        logic      empty;
        logic      not_ahead;
        logic      dpos_is_one;
        logic      out_free;
    } dp_stat_t;

endpackage

@@ hw/rtl/cfpq_if.sv @@
// request and result channel interfaces
interface cfpq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [28:0] msg_id;
    logic        msg_ide;
    logic        msg_rtr;
    logic [3:0]  msg_dlc;
    logic [63:0] msg_data;

    modport source (
        output valid, command, msg_id, msg_ide, msg_rtr, msg_dlc, msg_data,
        input  ready
    );
    modport sink (
        input  valid, command, msg_id, msg_ide, msg_rtr, msg_dlc, msg_data,
        output ready
    );
endinterface

interface cfpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        front_valid;
    logic [28:0] front_id;
    logic        front_ide;
    logic        front_rtr;
    logic [3:0]  front_dlc;
    logic [63:0] front_data;
    logic [4:0]  fill_count;

    modport source (
        output valid, status, front_valid, front_id, front_ide, front_rtr,
               front_dlc, front_data, fill_count,
        input  ready
    );
    modport sink (
        input  valid, status, front_valid, front_id, front_ide, front_rtr,
               front_dlc, front_data, fill_count,
        output ready
    );
endinterface

@@ hw/rtl/can_frame_priority_queue.sv @@
// top level of the can frame priority queue
//
//   channel  dir  handshake        carries
//   req      in   valid / ready    command and one can frame
//   rsp      out  valid / ready    status, front frame, fill count
//   cfg      in   cfg_wr_en        capacity, empties the queue
//
// one beat at a time: append, remove and no-op pass through the decide, front read and
// load states; priority insert also walks back from the tail and shifts up to 15 entries,
// one per walk step, bounded by the single ram write port.
// after reset the queue is empty with capacity 16; no clearing pass is needed.
// a result waiting on rsp holds the sequencer before the next accept.
module can_frame_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    cfpq_req_if.sink                    req,
    cfpq_rsp_if.source                  rsp,
    input  logic                        cfg_wr_en,
    input  logic [cfpq_pkg::FILL_W-1:0] cfg_wr_data
);
    import cfpq_pkg::*;

    ctl_t     ctl;
    dp_stat_t stat;

    cfpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    cfpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .stat        (stat)
    );

endmodule

@@ hw/rtl/cfpq_ram.sv @@
// generic single write port ram with registered read
module cfpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/cfpq_ctrl.sv @@
// sequencer for append, priority insert walk, remove and result load
module cfpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  cfpq_pkg::dp_stat_t stat,
    output cfpq_pkg::ctl_t     ctl
);
    import cfpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.in_fire)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.cmd == CMD_INSERT && !stat.full)
                begin
                    state_next = stat.empty ? S_PLACE : S_WALK;
                end
                else
                begin
                    state_next = S_FRONT_RD;
                end
            end
            S_WALK:
            begin
                if (stat.not_ahead)
                begin
                    state_next = S_FRONT_RD;
                end
                else if (stat.dpos_is_one)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:    state_next = S_FRONT_RD;
            S_FRONT_RD: state_next = S_LOAD;
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.status_val = ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
            end
            S_DECIDE:
            begin
                priority if ((stat.cmd == CMD_APPEND || stat.cmd == CMD_INSERT)
                             && stat.full)
                begin
                    ctl.status_we  = 1'b1;
                    ctl.status_val = ST_FULL;
                end
                else if (stat.cmd == CMD_APPEND)
                begin
                    ctl.append = 1'b1;
                end
                else if (stat.cmd == CMD_INSERT)
                begin
                    ctl.walk_start = 1'b1;
                end
                else if (stat.cmd == CMD_REMOVE && stat.empty)
                begin
                    ctl.status_we  = 1'b1;
                    ctl.status_val = ST_EMPTY;
                end
                else if (stat.cmd == CMD_REMOVE)
                begin
                    ctl.remove = 1'b1;
                end
                else
                begin
                    // unused command code leaves the queue as it is
                    ctl.status_val = ST_DONE;
                end
            end
            S_WALK:
            begin
                if (stat.not_ahead)
                begin
                    ctl.walk_place = 1'b1;
                end
                else
                begin
                    ctl.walk_shift = 1'b1;
                end
            end
            S_PLACE:
            begin
                ctl.walk_place = 1'b1;
            end
            S_FRONT_RD:
            begin
                ctl.front_rd = 1'b1;
            end
            S_LOAD:
            begin
                ctl.out_load = stat.out_free;
            end
            default:
            begin
                ctl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/cfpq_dp.sv @@
// queue datapath: capacity, head and fill registers, slot math, entry ram, result register
module cfpq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    cfpq_req_if.sink                    req,
    cfpq_rsp_if.source                  rsp,
    input  logic                        cfg_wr_en,
    input  logic [cfpq_pkg::FILL_W-1:0] cfg_wr_data,
    input  cfpq_pkg::ctl_t              ctl,
    output cfpq_pkg::dp_stat_t          stat
);
    import cfpq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int SW = ((IW > FILL_W) ? IW : FILL_W) + 1;
    localparam int CapLimInt = (DEPTH > 31) ? 31 : DEPTH;
    localparam logic [FILL_W-1:0] CapLim = FILL_W'(CapLimInt);

    logic [FILL_W-1:0] capacity_reg;
    logic [IW-1:0]     head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] dpos_reg;
    status_t           status_reg;
    frame_t            new_reg;
    cmd_code_t         cmd_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic              out_front_valid_reg;
    frame_t            out_frame_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic [FILL_W-1:0] eff_cap;
    frame_t            in_frame;
    logic [DATA_W-1:0] in_data;
    logic              in_fire;

    logic              wr_en;
    logic [FILL_W-1:0] wpos;
    logic [IW-1:0]     wr_addr;
    frame_t            wr_frame;
    logic              rd_en;
    logic [FILL_W-1:0] rpos;
    logic [IW-1:0]     rd_addr;
    logic [FRAME_W-1:0] rd_data;
    frame_t            rd_frame;

    // (head + pos) mod capacity; sum stays below twice the capacity
    function automatic logic [IW-1:0] slot_of(
        input logic [IW-1:0]     head,
        input logic [FILL_W-1:0] pos,
        input logic [FILL_W-1:0] cap
    );
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(pos);
        if (sum >= SW'(cap))
        begin
            sum = sum - SW'(cap);
        end
        return sum[IW-1:0];
    endfunction

    // new frame stays behind the stored one
    function automatic logic not_ahead_of(input frame_t nf, input frame_t of);
        logic r;
        if (!nf.ide && of.ide)
        begin
            r = 1'b1;
        end
        else if (nf.ide && !of.ide)
        begin
            r = 1'b0;
        end
        else
        begin
            r = (nf.id >= of.id);
        end
        return r;
    endfunction

    assign eff_cap = (capacity_reg == '0) ? FILL_W'(1) :
                     (capacity_reg > CapLim) ? CapLim : capacity_reg;

    assign req.ready = ctl.in_ready;
    assign in_fire   = req.valid & req.ready;

    // zero data bytes at or beyond the length code
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            in_data[8*b +: 8] = req.msg_data[8*b +: 8] & {8{req.msg_dlc > DLC_W'(b)}};
        end
        in_frame.dlc  = req.msg_dlc;
        in_frame.rtr  = req.msg_rtr;
        in_frame.ide  = req.msg_ide;
        in_frame.id   = req.msg_ide ? req.msg_id
                                    : {{(ID_W-STD_ID_W){1'b0}}, req.msg_id[STD_ID_W-1:0]};
        in_frame.data = in_data;
    end

    // ram port selection
    assign wr_en    = ctl.append | ctl.walk_shift | ctl.walk_place;
    assign wpos     = ctl.append ? fill_reg : dpos_reg;
    assign wr_addr  = slot_of(head_reg, wpos, eff_cap);
    assign wr_frame = ctl.walk_shift ? rd_frame : new_reg;

    always_comb
    begin
        priority if (ctl.walk_start)
        begin
            rpos = fill_reg - FILL_W'(1);
        end
        else if (ctl.walk_shift)
        begin
            rpos = dpos_reg - FILL_W'(2);
        end
        else if (ctl.remove)
        begin
            rpos = FILL_W'(1);
        end
        else
        begin
            rpos = '0;
        end
    end

    assign rd_addr  = slot_of(head_reg, rpos, eff_cap);
    assign rd_en    = (ctl.walk_start & (fill_reg != '0))
                    | (ctl.walk_shift & (dpos_reg != FILL_W'(1)))
                    | ctl.front_rd;
    assign rd_frame = frame_t'(rd_data);

    cfpq_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_frame),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= FILL_W'(16);
            head_reg     <= '0;
            fill_reg     <= '0;
            dpos_reg     <= '0;
            status_reg   <= ST_DONE;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
            head_reg     <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                status_reg <= ST_DONE;
            end
            if (ctl.status_we)
            begin
                status_reg <= ctl.status_val;
            end
            if (ctl.append)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (ctl.walk_start)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
                dpos_reg <= fill_reg;
            end
            if (ctl.walk_shift)
            begin
                dpos_reg <= dpos_reg - FILL_W'(1);
            end
            if (ctl.remove)
            begin
                head_reg <= rd_addr;
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            new_reg <= in_frame;
            cmd_reg <= req.command;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg      <= status_reg;
            out_fill_reg        <= fill_reg;
            out_front_valid_reg <= (fill_reg != '0);
            out_frame_reg       <= (fill_reg != '0) ? rd_frame : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.front_valid = out_front_valid_reg;
    assign rsp.front_id    = out_frame_reg.id;
    assign rsp.front_ide   = out_frame_reg.ide;
    assign rsp.front_rtr   = out_frame_reg.rtr;
    assign rsp.front_dlc   = out_frame_reg.dlc;
    assign rsp.front_data  = out_frame_reg.data;
    assign rsp.fill_count  = out_fill_reg;

    assign stat.in_fire     = in_fire;
    assign stat.cmd         = cmd_reg;
    assign stat.full        = (fill_reg >= eff_cap);
    assign stat.empty       = (fill_reg == '0);
    assign stat.not_ahead   = not_ahead_of(new_reg, rd_frame);
    assign stat.dpos_is_one = (dpos_reg == FILL_W'(1));
    assign stat.out_free    = ~out_valid_reg | rsp.ready;

endmodule

@@ bench/can_frame_priority_queue_test.sv @@
// self-checking testbench of the can frame priority queue with its own queue predictor
module can_frame_priority_queue_test;
    import cfpq_pkg::*;

    localparam cmd_code_t CMD_NOP = 2'd3;
    localparam int DEPTH = 16;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 140;
    localparam int RANDOM_PHASES = 13;
    localparam logic [ID_W-1:0] ID_ONES = '1;
    localparam logic [DATA_W-1:0] DATA_ONES = '1;

    typedef struct packed {
        cmd_code_t         command;
        logic [ID_W-1:0]   id;
        logic              ide;
        logic              rtr;
        logic [DLC_W-1:0]  dlc;
        logic [DATA_W-1:0] data;
    } frame_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              front_valid;
        logic [ID_W-1:0]   front_id;
        logic              front_ide;
        logic              front_rtr;
        logic [DLC_W-1:0]  front_dlc;
        logic [DATA_W-1:0] front_data;
        logic [FILL_W-1:0] fill_count;
    } front_report_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [FILL_W-1:0] cfg_wr_data;

    cfpq_req_if req_ch();
    cfpq_rsp_if rsp_ch();

    can_frame_priority_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // frames in queue order, front first
    frame_t        queued_frames[$];
    int unsigned   capacity_reg = 16;
    front_report_t expected_fronts[$];

    int mismatches = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int full_drops = 0;
    int empty_removes = 0;
    int cap_writes = 0;
    int idle_cycles = 0;
    bit quiet_phase = 1'b0;
    bit hold_off_pending = 1'b0;

    always #1 clk = ~clk;

    function automatic int unsigned active_slots();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > DEPTH)
            return DEPTH;
        return capacity_reg;
    endfunction

    // true when the new frame has to stay behind the stored one
    function automatic bit stays_behind(frame_t nf, frame_t sf);
        if (nf.ide != sf.ide)
            return sf.ide;
        return nf.id >= sf.id;
    endfunction

    function automatic front_report_t queue_step(frame_req_t r);
        frame_t        nf;
        front_report_t rep;
        int unsigned   nbytes;
        int            pos;
        int            c;
        nf.id = r.ide ? r.id : {{(ID_W-STD_ID_W){1'b0}}, r.id[STD_ID_W-1:0]};
        nf.ide = r.ide;
        nf.rtr = r.rtr;
        nf.dlc = r.dlc;
        nbytes = (r.dlc > 8) ? 8 : r.dlc;
        nf.data = (nbytes == 8) ? r.data : r.data & ((64'd1 << (8 * nbytes)) - 64'd1);
        rep = '0;
        rep.status = ST_DONE;
        case (r.command)
            CMD_APPEND, CMD_INSERT:
            begin
                if (queued_frames.size() >= active_slots())
                    rep.status = ST_FULL;
                else if (r.command == CMD_APPEND)
                    queued_frames.push_back(nf);
                else
                begin
                    // walk from the back until a frame is met that stays ahead
                    pos = 0;
                    for (c = queued_frames.size() - 1; c >= 0; c--)
                    begin
                        if (stays_behind(nf, queued_frames[c]))
                        begin
                            pos = c + 1;
                            break;
                        end
                    end
                    queued_frames.insert(pos, nf);
                end
            end
            CMD_REMOVE:
            begin
                if (queued_frames.size() == 0)
                    rep.status = ST_EMPTY;
                else
                    void'(queued_frames.pop_front());
            end
            default:
            begin
            end
        endcase
        if (queued_frames.size() > 0)
        begin
            rep.front_valid = 1'b1;
            rep.front_id = queued_frames[0].id;
            rep.front_ide = queued_frames[0].ide;
            rep.front_rtr = queued_frames[0].rtr;
            rep.front_dlc = queued_frames[0].dlc;
            rep.front_data = queued_frames[0].data;
        end
        rep.fill_count = FILL_W'(queued_frames.size());
        return rep;
    endfunction

    function automatic string describe(front_report_t r);
        return $sformatf("status %0d valid %0b id %h ide %0b rtr %0b dlc %0d data %h fill %0d",
                         r.status, r.front_valid, r.front_id, r.front_ide, r.front_rtr,
                         r.front_dlc, r.front_data, r.fill_count);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned roll;
        if (quiet_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic frame_req_t make_req(cmd_code_t cmd, logic [ID_W-1:0] id, logic ide,
                                            logic rtr, logic [DLC_W-1:0] dlc,
                                            logic [DATA_W-1:0] data);
        frame_req_t r;
        r.command = cmd;
        r.id = id;
        r.ide = ide;
        r.rtr = rtr;
        r.dlc = dlc;
        r.data = data;
        return r;
    endfunction

    function automatic frame_req_t random_request(int unsigned write_pct);
        frame_req_t  r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.command = CMD_NOP;
        else if (roll < 3 + write_pct)
            r.command = ($urandom_range(0, 99) < 65) ? CMD_INSERT : CMD_APPEND;
        else
            r.command = CMD_REMOVE;
        r.ide = 1'($urandom_range(0, 1));
        r.rtr = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 3);
        if (roll == 0)
            r.id = ID_W'($urandom());
        else if (roll == 1)
            r.id = ID_W'($urandom_range(0, 7));  // crowd of equal ids
        else if (roll == 2)
            r.id = ID_W'(($urandom() & ~32'h7FF) | $urandom_range(0, 7));
        else
            r.id = $urandom_range(0, 1) ? ID_ONES : '0;
        r.dlc = ($urandom_range(0, 9) < 8) ? DLC_W'($urandom_range(0, 8))
                                           : DLC_W'($urandom_range(9, 15));
        r.data = {$urandom(), $urandom()};
        return r;
    endfunction

    task automatic send_request(input frame_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= r.command;
        req_ch.msg_id <= r.id;
        req_ch.msg_ide <= r.ide;
        req_ch.msg_rtr <= r.rtr;
        req_ch.msg_dlc <= r.dlc;
        req_ch.msg_data <= r.data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_fronts.push_back(queue_step(r));
        requests_sent++;
    endtask

    task automatic release_and_drain();
        req_ch.valid <= 1'b0;
        while (expected_fronts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [FILL_W-1:0] value);
        release_and_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity_reg = value;
        queued_frames.delete();
        cap_writes++;
    endtask

    task automatic report_mismatch(input string what, input front_report_t want,
                                   input front_report_t seen);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t: %s", $realtime, what);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen));
        end
    endtask

    // ordering rules, id masking, data masking, empty and no-op cases at reset capacity
    task automatic test_directed_frames();
        send_request(make_req(CMD_REMOVE, '0, 1'b0, 1'b0, 4'd0, '0));
        send_request(make_req(CMD_NOP, ID_ONES, 1'b1, 1'b1, 4'd8, DATA_ONES));
        send_request(make_req(CMD_APPEND, ID_ONES, 1'b0, 1'b1, 4'd0, DATA_ONES));
        send_request(make_req(CMD_INSERT, ID_ONES, 1'b1, 1'b0, 4'd8, DATA_ONES));
        send_request(make_req(CMD_INSERT, '0, 1'b1, 1'b1, 4'd15, {$urandom(), $urandom()}));
        send_request(make_req(CMD_INSERT, '0, 1'b1, 1'b0, 4'd3, DATA_ONES));
        send_request(make_req(CMD_INSERT, '0, 1'b0, 1'b0, 4'd1, DATA_ONES));
        send_request(make_req(CMD_INSERT, 29'h7FF, 1'b0, 1'b1, 4'd7, DATA_ONES));
        send_request(make_req(CMD_APPEND, 29'd5, 1'b1, 1'b0, 4'd9, {$urandom(), $urandom()}));
        // standard frame stays behind an extended one at the back
        send_request(make_req(CMD_INSERT, 29'h400, 1'b0, 1'b0, 4'd2, DATA_ONES));
        send_request(make_req(CMD_NOP, '0, 1'b0, 1'b0, 4'd0, '0));
        repeat (5)
            send_request(make_req(CMD_REMOVE, ID_ONES, 1'b1, 1'b1, 4'd15, DATA_ONES));
        release_and_drain();
    endtask

    task automatic test_capacity_limits();
        write_capacity(5'd0);  // zero acts as a single entry
        send_request(make_req(CMD_APPEND, 29'd9, 1'b1, 1'b0, 4'd8, {$urandom(), $urandom()}));
        send_request(make_req(CMD_INSERT, 29'd1, 1'b1, 1'b0, 4'd4, DATA_ONES));
        send_request(make_req(CMD_APPEND, 29'd2, 1'b0, 1'b1, 4'd4, DATA_ONES));
        send_request(make_req(CMD_REMOVE, '0, 1'b0, 1'b0, 4'd0, '0));
        send_request(make_req(CMD_REMOVE, '0, 1'b0, 1'b0, 4'd0, '0));
        send_request(make_req(CMD_APPEND, 29'h123, 1'b0, 1'b0, 4'd8, DATA_ONES));
        // leave a frame queued so the next write has to empty it
        write_capacity(5'd31);
        send_request(make_req(CMD_REMOVE, '0, 1'b0, 1'b0, 4'd0, '0));
        send_request(make_req(CMD_INSERT, 29'd3, 1'b1, 1'b1, 4'd2, DATA_ONES));
        write_capacity(5'd17);
        send_request(make_req(CMD_NOP, '0, 1'b0, 1'b0, 4'd0, '0));
        release_and_drain();
    endtask

    // results held off long enough that the block must stall its input
    task automatic test_stalled_results();
        int i;
        write_capacity(5'd16);
        quiet_phase = 1'b1;
        hold_off_pending = 1'b1;
        for (i = 0; i < 40; i++)
            send_request(random_request(70));
        quiet_phase = 1'b0;
        release_and_drain();
    endtask

    task automatic test_random_traffic();
        logic [FILL_W-1:0] caps[12] = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd7, 5'd0,
                                        5'd16, 5'd17, 5'd4, 5'd12, 5'd3, 5'd16};
        int unsigned       mixes[3] = '{85, 55, 25};
        int unsigned       write_pct;
        int                p;
        int                i;
        write_pct = 55;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_capacity((p < 12) ? caps[p] : FILL_W'($urandom_range(0, 31)));
            quiet_phase = (p % 4 == 2);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // swing between filling and draining so full and empty both recur
                if (i % 20 == 0)
                    write_pct = mixes[$urandom_range(0, 2)];
                send_request(random_request(write_pct));
            end
        end
        quiet_phase = 1'b0;
        release_and_drain();
    endtask

    initial
    begin : result_sink
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : front_checker
        front_report_t seen;
        front_report_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen = {rsp_ch.status, rsp_ch.front_valid, rsp_ch.front_id, rsp_ch.front_ide,
                    rsp_ch.front_rtr, rsp_ch.front_dlc, rsp_ch.front_data, rsp_ch.fill_count};
            results_seen++;
            if (expected_fronts.size() == 0)
                report_mismatch("result beat with no request outstanding", '0, seen);
            else
            begin
                want = expected_fronts.pop_front();
                if (want.status == ST_FULL)
                    full_drops++;
                if (want.status == ST_EMPTY)
                    empty_removes++;
                if (seen !== want)
                    report_mismatch("result beat differs", want, seen);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_fronts.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.command <= CMD_APPEND;
        req_ch.msg_id <= '0;
        req_ch.msg_ide <= 1'b0;
        req_ch.msg_rtr <= 1'b0;
        req_ch.msg_dlc <= '0;
        req_ch.msg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_capacity_limits();
        test_stalled_results();
        test_random_traffic();
        release_and_drain();
        $display("sent %0d requests over %0d capacity settings, checked %0d results",
                 requests_sent, cap_writes, results_seen);
        $display("%0d writes dropped on a full queue, %0d removes on an empty one, %0d mismatches",
                 full_drops, empty_removes, mismatches);
        if (mismatches == 0 && expected_fronts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
